// File: design/cwac_pkg.sv
// Shared types and constants for the centered window average cutoff block.
// Used by cwac_ctrl, cwac_dpath and centered_window_average_cutoff.
package cwac_pkg;

  localparam int unsigned Q_W        = 17;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned TOT_W      = 17;
  localparam int unsigned HW_CFG_W   = 5;
  localparam int unsigned MAXC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [Q_W-1:0]      Q_ONE    = 17'd65536;
  localparam logic [IDX_W-1:0]    IDX_MAX  = 16'hFFFF;
  localparam logic [TOT_W-1:0]    TOT_MAX  = 17'd65536;

  localparam logic [HW_CFG_W-1:0] RST_HALF_WINDOW = 5'd4;
  localparam logic [Q_W-1:0]      RST_THRESHOLD   = 17'd32768;
  localparam logic                RST_COUNT_MODE  = 1'b0;
  localparam logic [MAXC_W-1:0]   RST_MAX_COUNT   = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WINDOW = 2'd0,
    CFG_THRESHOLD   = 2'd1,
    CFG_COUNT_MODE  = 2'd2,
    CFG_MAX_COUNT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic start_flush;
    logic start_one;
    logic setup;
    logic scan;
    logic set_stop;
    logic emit_item;
    logic emit_report;
    logic item_last;
    logic dec_d;
    logic pend_dec;
  } cwac_cmd_t;

  typedef struct packed {
    logic last_item;
    logic need_dec;
    logic stopped;
    logic scan_end;
    logic cut;
    logic d_zero;
    logic out_free;
  } cwac_sts_t;

endpackage

// File: design/centered_window_average_cutoff.sv
// Top level of the centered window average cutoff block.
// Instantiates cwac_ctrl and cwac_dpath; uses cwac_pkg.
//
// Usage: a ranked list of scored items arrives on the s_axis request channel,
// one item per request, tlast marking the list end. Each item is held until
// half_window later items have arrived (or the list ends), then its centered
// window average is tested against threshold (or the kept count against
// max_count in count mode). Kept items leave on m_axis with tuser low; after
// the list end one report (tuser high) carries the kept total. tlast on
// m_axis marks the final result caused by one input request.
// Sequence: an input is taken in IDLE, then checked in CHECK. Each decision
// scans the W-entry window (W at most 2*half_window+1) through the ring's
// single read port, one entry per cycle, via SETUP, SCAN, DRAIN, DECIDE and
// NEXT (only SETUP and NEXT once cut). A list end decides up to half_window+1
// items in turn, then the report. Input is accepted only between sequences.
// Reset clears configuration to defaults and empties list state; ring
// contents are not cleared. A stalled m_axis receiver holds the result
// register and the sequencer waits before loading the next result.
module centered_window_average_cutoff #(
  parameter int unsigned MAX_HALF_WINDOW = 16,
  parameter int unsigned ID_BITS         = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cwac_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cwac_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // item_id, quality
  input  logic [((ID_BITS+17+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // kept_id, kept_quality, kept_total
  output logic [((ID_BITS+34+7)/8)*8-1:0]       m_axis_tdata,
  // is_report
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int unsigned Q_W   = cwac_pkg::Q_W;
  localparam int unsigned TOT_W = cwac_pkg::TOT_W;
  localparam int unsigned M_W   = ((ID_BITS + 34 + 7) / 8) * 8;

  cwac_pkg::cwac_cmd_t cmd;
  cwac_pkg::cwac_sts_t sts;

  logic [ID_BITS-1:0] out_id;
  logic [Q_W-1:0]     out_quality;
  logic [TOT_W-1:0]   out_total;

  cwac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cwac_dpath #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .ID_BITS         (ID_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_id_i       (s_axis_tdata[ID_BITS-1:0]),
    .in_quality_i  (s_axis_tdata[ID_BITS+Q_W-1:ID_BITS]),
    .in_last_i     (s_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_id_o      (out_id),
    .out_quality_o (out_quality),
    .out_report_o  (m_axis_tuser),
    .out_total_o   (out_total),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = M_W'({out_total, out_quality, out_id});

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_item || cmd.emit_report) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded while result register occupied");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.setup, cmd.scan, cmd.emit_item, cmd.emit_report}))
    else $error("conflicting datapath commands");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("report result without tlast");

  a_intake_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken before previous item was checked");

endmodule

// File: design/cwac_dpath.sv
// Datapath: item ring memory, window sum accumulator, cut test, list counters,
// configuration registers and the result register. Depends on cwac_pkg.
module cwac_dpath #(
  parameter int unsigned MAX_HALF_WINDOW = 16,
  parameter int unsigned ID_BITS         = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cwac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cwac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ID_BITS-1:0]              in_id_i,
  input  logic [cwac_pkg::Q_W-1:0]        in_quality_i,
  input  logic                            in_last_i,
  input  cwac_pkg::cwac_cmd_t             cmd_i,
  output cwac_pkg::cwac_sts_t             sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [ID_BITS-1:0]              out_id_o,
  output logic [cwac_pkg::Q_W-1:0]        out_quality_o,
  output logic                            out_report_o,
  output logic [cwac_pkg::TOT_W-1:0]      out_total_o,
  output logic                            out_last_o
);

  localparam int unsigned Q_W    = cwac_pkg::Q_W;
  localparam int unsigned IDX_W  = cwac_pkg::IDX_W;
  localparam int unsigned TOT_W  = cwac_pkg::TOT_W;
  localparam int unsigned RING_D = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned PTR_W  = $clog2(RING_D);
  localparam int unsigned AS_W   = PTR_W + 1;
  localparam int unsigned HW_W   = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned PEND_W = $clog2(MAX_HALF_WINDOW + 2);
  localparam int unsigned CNT_W  = $clog2(RING_D + 1);
  localparam int unsigned SUM_W  = Q_W + CNT_W;
  localparam int unsigned ENT_W  = ID_BITS + Q_W;

  // configuration
  logic [cwac_pkg::HW_CFG_W-1:0] hw_cfg_q;
  logic [Q_W-1:0]                thr_q;
  logic                          cmode_q;
  logic [cwac_pkg::MAXC_W-1:0]   maxc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_cfg_q <= cwac_pkg::RST_HALF_WINDOW;
      thr_q    <= cwac_pkg::RST_THRESHOLD;
      cmode_q  <= cwac_pkg::RST_COUNT_MODE;
      maxc_q   <= cwac_pkg::RST_MAX_COUNT;
    end else if (cfg_we_i) begin
      case (cwac_pkg::cfg_idx_e'(cfg_idx_i))
        cwac_pkg::CFG_HALF_WINDOW: hw_cfg_q <= cfg_data_i[cwac_pkg::HW_CFG_W-1:0];
        cwac_pkg::CFG_THRESHOLD:   thr_q    <= cfg_data_i[Q_W-1:0];
        cwac_pkg::CFG_COUNT_MODE:  cmode_q  <= cfg_data_i[0];
        cwac_pkg::CFG_MAX_COUNT:   maxc_q   <= cfg_data_i[cwac_pkg::MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  // list state
  logic [PTR_W-1:0]  wr_pos_q;
  logic [IDX_W-1:0]  item_idx_q;
  logic [PEND_W-1:0] pending_q;
  logic [HW_W-1:0]   list_hw_q;
  logic [TOT_W-1:0]  kept_q;
  logic              stop_q;
  logic              last_q;

  logic [Q_W-1:0]  q_sat;
  logic [HW_W-1:0] hw_clamp;
  logic [PTR_W-1:0] wr_pos_d;

  assign q_sat    = (in_quality_i > cwac_pkg::Q_ONE) ? cwac_pkg::Q_ONE : in_quality_i;
  assign hw_clamp = (hw_cfg_q > cwac_pkg::HW_CFG_W'(MAX_HALF_WINDOW)) ?
                    HW_W'(MAX_HALF_WINDOW) : hw_cfg_q[HW_W-1:0];
  assign wr_pos_d = (wr_pos_q == PTR_W'(RING_D - 1)) ? '0 : wr_pos_q + PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q   <= '0;
      item_idx_q <= '0;
      pending_q  <= '0;
      list_hw_q  <= '0;
      kept_q     <= '0;
      stop_q     <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        wr_pos_q <= wr_pos_d;
        last_q   <= in_last_i;
        if (item_idx_q == '0) begin
          list_hw_q <= hw_clamp;
        end
        if (item_idx_q != cwac_pkg::IDX_MAX) begin
          item_idx_q <= item_idx_q + IDX_W'(1);
        end
        pending_q <= pending_q + PEND_W'(1);
      end
      if (cmd_i.pend_dec) begin
        pending_q <= pending_q - PEND_W'(1);
      end
      if (cmd_i.set_stop) begin
        stop_q <= 1'b1;
      end
      if (cmd_i.emit_item && kept_q != cwac_pkg::TOT_MAX) begin
        kept_q <= kept_q + TOT_W'(1);
      end
      if (cmd_i.emit_report) begin
        item_idx_q <= '0;
        pending_q  <= '0;
        list_hw_q  <= '0;
        kept_q     <= '0;
        stop_q     <= 1'b0;
      end
    end
  end

  // window scan
  logic [HW_W-1:0]  d_q;
  logic [PTR_W-1:0] span_q;
  logic [PTR_W-1:0] k_q;
  logic [SUM_W-1:0] acc_q;
  logic [ENT_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic             rd_cap_q;
  logic [ID_BITS-1:0] cap_id_q;
  logic [Q_W-1:0]     cap_q_q;

  logic [IDX_W-1:0] older;
  logic [HW_W-1:0]  lefts;
  logic [PTR_W-1:0] span_d;
  logic [AS_W-1:0]  rd_tmp;
  logic [PTR_W-1:0] rd_addr;

  assign older   = item_idx_q - IDX_W'(1) - IDX_W'(d_q);
  assign lefts   = (older < IDX_W'(list_hw_q)) ? older[HW_W-1:0] : list_hw_q;
  assign span_d  = PTR_W'(d_q) + PTR_W'(lefts);
  assign rd_tmp  = AS_W'(wr_pos_q) + AS_W'(RING_D - 1) - AS_W'(k_q);
  assign rd_addr = (rd_tmp >= AS_W'(RING_D)) ? PTR_W'(rd_tmp - AS_W'(RING_D)) : PTR_W'(rd_tmp);

  logic [ENT_W-1:0] ring_mem [RING_D];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[wr_pos_q] <= {in_id_i, q_sat};
    end
    if (cmd_i.scan) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_flush) begin
      d_q <= HW_W'(pending_q - PEND_W'(1));
    end else if (cmd_i.start_one) begin
      d_q <= list_hw_q;
    end else if (cmd_i.dec_d) begin
      d_q <= d_q - HW_W'(1);
    end
    if (cmd_i.setup) begin
      span_q <= span_d;
      k_q    <= '0;
    end else if (cmd_i.scan) begin
      k_q <= k_q + PTR_W'(1);
    end
    if (cmd_i.scan) begin
      rd_cap_q <= (k_q == PTR_W'(d_q));
    end
    if (cmd_i.setup) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + SUM_W'(rd_data_q[Q_W-1:0]);
    end
    if (rd_vld_q && rd_cap_q) begin
      cap_id_q <= rd_data_q[ENT_W-1:Q_W];
      cap_q_q  <= rd_data_q[Q_W-1:0];
    end
  end

  // cut test: sum < threshold * count, or kept count >= max_count in count mode
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] thr_mul;
  logic             cut;

  assign cnt     = CNT_W'(span_q) + CNT_W'(1);
  assign thr_mul = SUM_W'(thr_q) * SUM_W'(cnt);
  assign cut     = cmode_q ? (kept_q >= TOT_W'(maxc_q)) : (acc_q < thr_mul);

  // result register
  logic               out_valid_q;
  logic [ID_BITS-1:0] out_id_q;
  logic [Q_W-1:0]     out_quality_q;
  logic               out_report_q;
  logic [TOT_W-1:0]   out_total_q;
  logic               out_last_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_item || cmd_i.emit_report) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_item) begin
      out_id_q      <= cap_id_q;
      out_quality_q <= cap_q_q;
      out_report_q  <= 1'b0;
      out_total_q   <= '0;
      out_last_q    <= cmd_i.item_last;
    end else if (cmd_i.emit_report) begin
      out_id_q      <= '0;
      out_quality_q <= '0;
      out_report_q  <= 1'b1;
      out_total_q   <= kept_q;
      out_last_q    <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_id_o      = out_id_q;
  assign out_quality_o = out_quality_q;
  assign out_report_o  = out_report_q;
  assign out_total_o   = out_total_q;
  assign out_last_o    = out_last_q;

  assign sts_o.last_item = last_q;
  assign sts_o.need_dec  = pending_q > PEND_W'(list_hw_q);
  assign sts_o.stopped   = stop_q;
  assign sts_o.scan_end  = (k_q == span_q);
  assign sts_o.cut       = cut;
  assign sts_o.d_zero    = (d_q == '0);
  assign sts_o.out_free  = out_free;

endmodule

// File: design/cwac_ctrl.sv
// Controller: sequences item intake, window scans, decisions and the report.
// Depends on cwac_pkg; drives cwac_dpath through command and status structs.
module cwac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cwac_pkg::cwac_sts_t sts_i,
  output cwac_pkg::cwac_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_NEXT,
    ST_REPORT
  } state_e;

  state_e state_q;
  logic   flush_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      flush_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sts_i.last_item) begin
            flush_q <= 1'b1;
            state_q <= ST_SETUP;
          end else if (sts_i.need_dec) begin
            flush_q <= 1'b0;
            state_q <= ST_SETUP;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SETUP: begin
          state_q <= sts_i.stopped ? ST_NEXT : ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.scan_end) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (sts_i.cut || sts_i.out_free) begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (!flush_q) begin
            state_q <= ST_IDLE;
          end else if (sts_i.d_zero) begin
            state_q <= ST_REPORT;
          end else begin
            state_q <= ST_SETUP;
          end
        end
        ST_REPORT: begin
          if (sts_i.out_free) begin
            flush_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:  cmd_o.accept = in_valid_i;
      ST_CHECK: begin
        cmd_o.start_flush = sts_i.last_item;
        cmd_o.start_one   = !sts_i.last_item && sts_i.need_dec;
      end
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_SCAN:  cmd_o.scan  = 1'b1;
      ST_DECIDE: begin
        cmd_o.set_stop  = sts_i.cut;
        cmd_o.emit_item = !sts_i.cut && sts_i.out_free;
        cmd_o.item_last = !flush_q;
      end
      ST_NEXT: begin
        cmd_o.dec_d    = flush_q && !sts_i.d_zero;
        cmd_o.pend_dec = !flush_q;
      end
      ST_REPORT: cmd_o.emit_report = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: verif/centered_window_average_cutoff_tb.sv
// Self-checking bench for centered_window_average_cutoff: streams ranked score lists,
// predicts kept items and end-of-list reports in a local model, checks m_axis in order.
// Depends on cwac_pkg and the centered_window_average_cutoff RTL.
module centered_window_average_cutoff_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Q_W        = cwac_pkg::Q_W;
  localparam int unsigned TOT_W      = cwac_pkg::TOT_W;
  localparam int unsigned HW_CFG_W   = cwac_pkg::HW_CFG_W;
  localparam int unsigned MAXC_W     = cwac_pkg::MAXC_W;
  localparam int unsigned CFG_DATA_W = cwac_pkg::CFG_DATA_W;
  localparam logic [Q_W-1:0] Q_ONE   = cwac_pkg::Q_ONE;

  localparam int unsigned HW_MAX    = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned RING_LEN  = 2 * HW_MAX + 1;
  localparam int unsigned S_DATA_W  = ((ID_W + 17 + 7) / 8) * 8;
  localparam int unsigned M_DATA_W  = ((ID_W + 34 + 7) / 8) * 8;
  localparam int unsigned SETTLE    = 100;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [Q_W-1:0]  quality;
    logic            last;
  } list_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  kept_id;
    logic [Q_W-1:0]   kept_quality;
    logic             is_report;
    logic [TOT_W-1:0] kept_total;
    logic             last;
  } kept_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  cwac_pkg::cfg_idx_e    cfg_idx_i     = cwac_pkg::CFG_HALF_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tready = 1'b0;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire  [M_DATA_W-1:0]   m_axis_tdata;
  wire                   m_axis_tuser;
  wire                   m_axis_tlast;

  centered_window_average_cutoff #(
    .MAX_HALF_WINDOW(HW_MAX),
    .ID_BITS        (ID_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // register copies
  logic [HW_CFG_W-1:0] hw_cfg    = cwac_pkg::RST_HALF_WINDOW;
  logic [Q_W-1:0]      thr_cfg   = cwac_pkg::RST_THRESHOLD;
  logic                cmode_cfg = cwac_pkg::RST_COUNT_MODE;
  logic [MAXC_W-1:0]   maxc_cfg  = cwac_pkg::RST_MAX_COUNT;

  // list state
  logic [Q_W-1:0]  score_hist [RING_LEN];
  logic [ID_W-1:0] id_hist    [RING_LEN];
  int unsigned     hist_wr     = 0;
  int unsigned     list_pos    = 0;
  int unsigned     kept_so_far = 0;
  int unsigned     undecided   = 0;
  int unsigned     win_half    = 0;
  bit              list_cut    = 1'b0;

  kept_result_t step_out [$];
  kept_result_t awaited_q [$];
  list_item_t   feed_q [$];
  list_item_t   riding;

  int unsigned     sender_idle_pct   = 32;
  int unsigned     receiver_idle_pct = 84;
  int unsigned     mismatches        = 0;
  longint unsigned cycles            = 0;

  function automatic int unsigned hist_slot(input int unsigned back);
    return (hist_wr + 2 * RING_LEN - 1 - back) % RING_LEN;
  endfunction

  // decide the item d requests older than the newest, d later neighbors in its window
  task automatic decide_window(input int unsigned d);
    int unsigned     older;
    int unsigned     lefts;
    int unsigned     cnt;
    int unsigned     k;
    longint unsigned sum;
    bit              cut;
    kept_result_t    r;
    older = (list_pos >= d + 1) ? list_pos - 1 - d : 0;
    lefts = (older < win_half) ? older : win_half;
    sum = 0;
    for (k = 0; k <= d + lefts; k++) sum += score_hist[hist_slot(k)];
    cnt = lefts + d + 1;
    if (!list_cut) begin
      if (cmode_cfg) begin
        cut = (kept_so_far >= maxc_cfg);
      end else begin
        cut = (sum < longint'(thr_cfg) * cnt);
      end
      if (cut) begin
        list_cut = 1'b1;
      end else begin
        r = '0;
        r.kept_id      = id_hist[hist_slot(d)];
        r.kept_quality = score_hist[hist_slot(d)];
        step_out = {step_out, r};
        if (kept_so_far < 65536) kept_so_far++;
      end
    end
  endtask

  task automatic cutoff_step(input list_item_t it);
    logic [Q_W-1:0] q;
    kept_result_t   r;
    step_out.delete();
    q = (it.quality > Q_ONE) ? Q_ONE : it.quality;
    if (list_pos == 0) win_half = (hw_cfg < HW_MAX) ? 32'(hw_cfg) : HW_MAX;
    score_hist[hist_wr] = q;
    id_hist[hist_wr]    = it.id;
    hist_wr = (hist_wr + 1) % RING_LEN;
    if (list_pos < 65535) list_pos++;
    undecided++;
    if (it.last) begin
      while (undecided > 0) begin
        decide_window(undecided - 1);
        undecided--;
      end
      r = '0;
      r.is_report  = 1'b1;
      r.kept_total = TOT_W'(kept_so_far);
      step_out = {step_out, r};
      list_pos    = 0;
      kept_so_far = 0;
      list_cut    = 1'b0;
      win_half    = 0;
    end else if (undecided > win_half) begin
      decide_window(win_half);
      undecided--;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    awaited_q = {awaited_q, step_out};
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) cutoff_step(riding);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          riding = feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_DATA_W'({riding.quality, riding.id});
          s_axis_tlast  <= riding.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    kept_result_t got;
    kept_result_t want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kept_id      = m_axis_tdata[ID_W-1:0];
        got.kept_quality = m_axis_tdata[ID_W+Q_W-1:ID_W];
        got.kept_total   = m_axis_tdata[ID_W+Q_W+TOT_W-1:ID_W+Q_W];
        got.is_report    = m_axis_tuser;
        got.last         = m_axis_tlast;
        if (awaited_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result id %h report %b", got.kept_id,
                                  got.is_report));
        end else begin
          want = awaited_q.pop_front();
          if (got.kept_id !== want.kept_id)
            flag_mismatch($sformatf("kept_id %h, want %h", got.kept_id, want.kept_id));
          if (got.kept_quality !== want.kept_quality)
            flag_mismatch($sformatf("kept_quality %h, want %h", got.kept_quality,
                                    want.kept_quality));
          if (got.is_report !== want.is_report)
            flag_mismatch($sformatf("is_report %b, want %b", got.is_report, want.is_report));
          if (got.kept_total !== want.kept_total)
            flag_mismatch($sformatf("kept_total %0d, want %0d", got.kept_total,
                                    want.kept_total));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("centered_window_average_cutoff_tb: errors");
      $finish;
    end
  end

  task automatic queue_item(input logic [ID_W-1:0] id, input logic [Q_W-1:0] q,
                            input logic last);
    list_item_t it;
    it.id      = id;
    it.quality = q;
    it.last    = last;
    feed_q = {feed_q, it};
  endtask

  task automatic write_reg(input cwac_pkg::cfg_idx_e idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      cwac_pkg::CFG_HALF_WINDOW: hw_cfg    = val[HW_CFG_W-1:0];
      cwac_pkg::CFG_THRESHOLD:   thr_cfg   = val[Q_W-1:0];
      cwac_pkg::CFG_COUNT_MODE:  cmode_cfg = val[0];
      cwac_pkg::CFG_MAX_COUNT:   maxc_cfg  = val[MAXC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic await_idle;
    while (feed_q.size() != 0 || s_axis_tvalid || awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [Q_W-1:0] pick_quality;
    int unsigned t;
    int unsigned v;
    t = 32'(thr_cfg);
    case ($urandom_range(19))
      0:                      v = 0;
      1:                      v = 32'(Q_ONE);
      2:                      v = $urandom_range(65537, 131071);
      3, 4:                   v = $urandom_range(0, 65536);
      5, 6, 7, 8, 9, 10, 11:  v = t + $urandom_range(0, 6000);
      default:                v = (t > 6000) ? t - $urandom_range(1, 6000) : $urandom_range(0, t);
    endcase
    if (v > 131071) v = 131071;
    return v[Q_W-1:0];
  endfunction

  function automatic int unsigned pick_length;
    case ($urandom_range(9))
      0:       return 1;
      7, 8:    return $urandom_range(13, 24);
      9:       return $urandom_range(34, 45);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  task automatic feed_list(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++)
      queue_item(ID_W'($urandom), pick_quality(), close && (i == len - 1));
  endtask

  task automatic shuffle_registers;
    logic [CFG_DATA_W-1:0] val;
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = CFG_DATA_W'(HW_MAX);
      2:       val = CFG_DATA_W'($urandom_range(17, 31));
      default: val = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    write_reg(cwac_pkg::CFG_HALF_WINDOW, val);
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = Q_ONE;
      2:       val = CFG_DATA_W'($urandom_range(65537, 131071));
      default: val = CFG_DATA_W'($urandom_range(16384, 49152));
    endcase
    write_reg(cwac_pkg::CFG_THRESHOLD, val);
    write_reg(cwac_pkg::CFG_COUNT_MODE, CFG_DATA_W'($urandom_range(3) == 0));
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = CFG_DATA_W'(16'hFFFF);
      default: val = CFG_DATA_W'($urandom_range(0, 12));
    endcase
    write_reg(cwac_pkg::CFG_MAX_COUNT, val);
    close_writes();
  endtask

  initial begin
    int unsigned m;
    int unsigned p;
    int unsigned n;
    int unsigned fed;
    bit          open_list;
    open_list = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: lone cut item, lone full-score item, scores above one
    queue_item(16'hFFFF, 17'd0, 1'b1);
    queue_item(16'h0000, Q_ONE, 1'b1);
    queue_item(16'h0001, 17'h1FFFF, 1'b0);
    queue_item(16'h0002, 17'd100000, 1'b0);
    queue_item(16'h0003, 17'd70000, 1'b1);
    // cut partway, later items received but dropped
    for (int unsigned i = 0; i < 10; i++)
      queue_item(ID_W'(16'h8000 + i), (i < 5) ? Q_ONE : 17'd0, i == 9);
    await_idle();

    // oversized window, average exactly at threshold
    write_reg(cwac_pkg::CFG_HALF_WINDOW, CFG_DATA_W'(31));
    write_reg(cwac_pkg::CFG_THRESHOLD, Q_ONE);
    close_writes();
    for (int unsigned i = 0; i < 3; i++) queue_item(ID_W'(16'h4000 + i), Q_ONE, i == 2);
    await_idle();

    // fixed count mode
    write_reg(cwac_pkg::CFG_COUNT_MODE, CFG_DATA_W'(1));
    write_reg(cwac_pkg::CFG_MAX_COUNT, CFG_DATA_W'(2));
    write_reg(cwac_pkg::CFG_HALF_WINDOW, CFG_DATA_W'(0));
    close_writes();
    for (int unsigned i = 0; i < 4; i++)
      queue_item(ID_W'(16'h2000 + i), pick_quality(), i == 3);
    await_idle();

    // window written mid-list only applies to the next list
    write_reg(cwac_pkg::CFG_COUNT_MODE, CFG_DATA_W'(0));
    write_reg(cwac_pkg::CFG_HALF_WINDOW, CFG_DATA_W'(2));
    write_reg(cwac_pkg::CFG_THRESHOLD, CFG_DATA_W'(0));
    close_writes();
    queue_item(16'h1000, Q_ONE, 1'b0);
    queue_item(16'h1001, 17'd0, 1'b0);
    queue_item(16'h1002, Q_ONE, 1'b0);
    await_idle();
    write_reg(cwac_pkg::CFG_HALF_WINDOW, CFG_DATA_W'(0));
    write_reg(cwac_pkg::CFG_THRESHOLD, 17'd32768);
    close_writes();
    queue_item(16'h1003, Q_ONE, 1'b0);
    queue_item(16'h1004, Q_ONE, 1'b1);

    for (m = 0; m < 3; m++) begin
      await_idle();
      case (m)
        0: begin
          sender_idle_pct   = 32;
          receiver_idle_pct = 84;
        end
        1: begin
          sender_idle_pct   = 84;
          receiver_idle_pct = 32;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (p = 0; p < 3; p++) begin
        await_idle();
        shuffle_registers();
        fed = 0;
        if (open_list) begin
          n = $urandom_range(1, 6);
          feed_list(n, 1'b1);
          fed += n;
          open_list = 1'b0;
        end
        while (fed < 10) begin
          n = pick_length();
          feed_list(n, 1'b1);
          fed += n;
        end
        if ((m != 2 || p != 2) && $urandom_range(3) == 0) begin
          feed_list($urandom_range(1, 8), 1'b0);
          open_list = 1'b1;
        end
      end
    end
    await_idle();

    if (mismatches == 0) begin
      $display("centered_window_average_cutoff_tb: clean");
    end else begin
      $display("centered_window_average_cutoff_tb: errors");
    end
    $finish;
  end

endmodule
